// File: rtl/fbt_pkg.sv
package fbt_pkg;

  // Coordinate and basis word widths.
  localparam int CoordW = 32;
  localparam int BasisW = 32;
  localparam int ScaleW = 31;

  // Width of an unnormalised cross product of two Q1.30 vectors.
  localparam int CrossW = 63;

  // Register reset value: a scale of one in unsigned Q15.16.
  localparam logic [ScaleW-1:0] ScaleReset = 31'd65536;

  // Parallel thresholds: 0.98 in Q.60 and in Q1.30, both rounded down.
  localparam logic [62:0] CosLimQ60 = 63'd1129863074514710036;
  localparam logic [31:0] CosLimQ30 = 32'd1052266987;

  // Action codes.
  localparam logic ActForward = 1'b0;
  localparam logic ActInverse = 1'b1;

  typedef struct packed {
    logic                     action;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic signed [CoordW-1:0] axis_x;
    logic signed [CoordW-1:0] axis_y;
    logic signed [CoordW-1:0] axis_z;
    logic signed [CoordW-1:0] up_x;
    logic signed [CoordW-1:0] up_y;
    logic signed [CoordW-1:0] up_z;
  } fbt_in_t;

  typedef struct packed {
    logic signed [BasisW-1:0] m00;
    logic signed [BasisW-1:0] m01;
    logic signed [BasisW-1:0] m02;
    logic signed [BasisW-1:0] m10;
    logic signed [BasisW-1:0] m11;
    logic signed [BasisW-1:0] m12;
    logic signed [BasisW-1:0] m20;
    logic signed [BasisW-1:0] m21;
    logic signed [BasisW-1:0] m22;
    logic signed [CoordW-1:0] t0;
    logic signed [CoordW-1:0] t1;
    logic signed [CoordW-1:0] t2;
  } fbt_out_t;

  // Position, action and basis vectors carried alongside the pipeline.
  typedef struct packed {
    logic                     action;
    logic [2:0][CoordW-1:0]   pos;
  } fbt_head_t;

  typedef struct packed {
    fbt_head_t                head;
    logic [2:0][BasisW-1:0]   xb;
  } fbt_side1_t;

  typedef struct packed {
    fbt_head_t                head;
    logic [2:0][BasisW-1:0]   xb;
    logic [2:0][BasisW-1:0]   zb;
  } fbt_side2_t;

endpackage

// File: rtl/fbt_norm.sv
module fbt_norm import fbt_pkg::*; #(
  parameter int IN_W   = CoordW,
  parameter int SIDE_W = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [2:0][IN_W-1:0]     vec_i,
  input  logic [SIDE_W-1:0]        side_i,
  output logic                     valid_o,
  output logic [2:0][BasisW-1:0]   vec_o,
  output logic [SIDE_W-1:0]        side_o
);

  localparam int PosW    = $clog2(IN_W);
  localparam int SqSteps = 31;
  localparam int DvSteps = 31;

  typedef struct packed {
    logic [SIDE_W-1:0] side;
    logic [2:0]        neg;
    logic              zero;
    logic [2:0][29:0]  sh;
  } carry_t;

  // Magnitudes, maximum and leading one position.
  logic                   v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [2:0][IN_W-1:0]   mag1_q, mag2_q, mag3_q;
  logic [2:0]             neg1_q, neg2_q, neg3_q;
  logic [SIDE_W-1:0]      sd1_q, sd2_q, sd3_q;
  logic [IN_W-1:0]        mx2_q;
  logic [PosW-1:0]        pos3_q;
  logic                   zero3_q;
  carry_t                 cb4_q, cb5_q;
  logic [2:0][59:0]       sq5_q;

  logic [IN_W-1:0]        mx_d;
  logic [PosW-1:0]        pos_d;
  logic [2:0][29:0]       sh_d;
  logic [PosW-1:0]        rs, ls;

  always_comb begin
    mx_d = mag1_q[0];
    if (mag1_q[1] > mx_d) mx_d = mag1_q[1];
    if (mag1_q[2] > mx_d) mx_d = mag1_q[2];
  end

  always_comb begin
    pos_d = '0;
    for (int b = 0; b < IN_W; b++) begin
      if (mx2_q[b]) pos_d = PosW'(b);
    end
  end

  always_comb begin
    logic [IN_W-1:0] t;
    rs = pos3_q - PosW'(29);
    ls = PosW'(29) - pos3_q;
    for (int i = 0; i < 3; i++) begin
      if (pos3_q >= PosW'(29)) t = mag3_q[i] >> rs;
      else t = mag3_q[i] << ls;
      sh_d[i] = t[29:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      neg1_q[i] <= vec_i[i][IN_W-1];
      mag1_q[i] <= vec_i[i][IN_W-1] ? (~vec_i[i] + IN_W'(1)) : vec_i[i];
    end
    sd1_q   <= side_i;
    mag2_q  <= mag1_q;
    neg2_q  <= neg1_q;
    sd2_q   <= sd1_q;
    mx2_q   <= mx_d;
    mag3_q  <= mag2_q;
    neg3_q  <= neg2_q;
    sd3_q   <= sd2_q;
    pos3_q  <= pos_d;
    zero3_q <= (mx2_q == '0);
    cb4_q.side <= sd3_q;
    cb4_q.neg  <= neg3_q;
    cb4_q.zero <= zero3_q;
    cb4_q.sh   <= sh_d;
    cb5_q <= cb4_q;
    for (int i = 0; i < 3; i++) begin
      sq5_q[i] <= cb4_q.sh[i] * cb4_q.sh[i];
    end
  end

  // Square root, one result bit per stage; stage 0 holds the sum of squares.
  logic [SqSteps:0] sv_q;
  logic [61:0]      rad_q  [SqSteps+1];
  logic [32:0]      rem_q  [SqSteps+1];
  logic [30:0]      root_q [SqSteps+1];
  carry_t           scb_q  [SqSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_q[0] <= 1'b0;
    else sv_q[0] <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    rad_q[0]  <= 62'(sq5_q[0]) + 62'(sq5_q[1]) + 62'(sq5_q[2]);
    rem_q[0]  <= '0;
    root_q[0] <= '0;
    scb_q[0]  <= cb5_q;
  end

  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    logic [34:0] rt, tr;
    logic        ge;
    assign rt = {rem_q[k], rad_q[k][61:60]};
    assign tr = {2'b00, root_q[k], 2'b01};
    assign ge = (rt >= tr);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[k+1] <= 1'b0;
      else sv_q[k+1] <= sv_q[k];
    end

    always_ff @(posedge clk_i) begin
      rad_q[k+1]  <= {rad_q[k][59:0], 2'b00};
      rem_q[k+1]  <= ge ? 33'(rt - tr) : 33'(rt);
      root_q[k+1] <= {root_q[k][29:0], ge};
      scb_q[k+1]  <= scb_q[k];
    end
  end

  // Division of each component by the length, one quotient bit per stage.
  logic [DvSteps:0]   dv_q;
  logic [2:0][30:0]   drem_q [DvSteps+1];
  logic [2:0][30:0]   nb_q   [DvSteps+1];
  logic [2:0][30:0]   quo_q  [DvSteps+1];
  logic [30:0]        len_q  [DvSteps+1];
  carry_t             dcb_q  [DvSteps+1];

  logic [2:0][60:0]   num_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_d[i] = {1'b0, scb_q[SqSteps].sh[i], 30'd0} + 61'(root_q[SqSteps][30:1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q[0] <= 1'b0;
    else dv_q[0] <= sv_q[SqSteps];
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      drem_q[0][i] <= {1'b0, num_d[i][60:31]};
      nb_q[0][i]   <= num_d[i][30:0];
      quo_q[0][i]  <= '0;
    end
    len_q[0] <= root_q[SqSteps];
    dcb_q[0] <= scb_q[SqSteps];
  end

  for (genvar k = 0; k < DvSteps; k++) begin : g_div
    logic [2:0][31:0] rt;
    logic [2:0]       ge;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rt[i] = {drem_q[k][i], nb_q[k][i][30]};
        ge[i] = (rt[i] >= {1'b0, len_q[k]});
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[k+1] <= 1'b0;
      else dv_q[k+1] <= dv_q[k];
    end

    always_ff @(posedge clk_i) begin
      for (int i = 0; i < 3; i++) begin
        drem_q[k+1][i] <= ge[i] ? 31'(rt[i] - {1'b0, len_q[k]}) : rt[i][30:0];
        nb_q[k+1][i]   <= {nb_q[k][i][29:0], 1'b0};
        quo_q[k+1][i]  <= {quo_q[k][i][29:0], ge[i]};
      end
      len_q[k+1] <= len_q[k];
      dcb_q[k+1] <= dcb_q[k];
    end
  end

  // Sign restore and output register.
  logic                   vo_q;
  logic [2:0][BasisW-1:0] vec_q;
  logic [SIDE_W-1:0]      sdo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else vo_q <= dv_q[DvSteps];
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (dcb_q[DvSteps].zero) vec_q[i] <= '0;
      else if (dcb_q[DvSteps].neg[i]) vec_q[i] <= -{1'b0, quo_q[DvSteps][i]};
      else vec_q[i] <= {1'b0, quo_q[DvSteps][i]};
    end
    sdo_q <= dcb_q[DvSteps].side;
  end

  assign valid_o = vo_q;
  assign vec_o   = vec_q;
  assign side_o  = sdo_q;

endmodule

// File: rtl/fbt_cross.sv
module fbt_cross import fbt_pkg::*; #(
  parameter bit PAR_EN = 1'b1,
  parameter int SIDE_W = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [2:0][BasisW-1:0]   a_i,
  input  logic [2:0][BasisW-1:0]   b_i,
  input  logic [SIDE_W-1:0]        side_i,
  output logic                     valid_o,
  output logic [2:0][CrossW-1:0]   c_o,
  output logic [SIDE_W-1:0]        side_o
);

  logic                          v1_q, v2_q, v3_q;
  logic signed [2:0][1:0][63:0]  pr1_q;
  logic signed [2:0][63:0]       dp1_q;
  logic [2:0][BasisW-1:0]        a1_q;
  logic [SIDE_W-1:0]             sd1_q, sd2_q, sd3_q;
  logic [2:0][CrossW-1:0]        cr2_q, alt2_q, c3_q;
  logic signed [63:0]            dot2_q;

  logic signed [2:0][1:0][63:0]  pr_d;
  logic signed [2:0][63:0]       dp_d;
  logic [2:0][CrossW-1:0]        alt_d;
  logic [63:0]                   dmag;
  logic [BasisW-1:0]             a0mag;

  // Products for a x b and for the dot product.
  always_comb begin
    logic signed [BasisW-1:0] a0, a1, a2, b0, b1, b2;
    a0 = a_i[0]; a1 = a_i[1]; a2 = a_i[2];
    b0 = b_i[0]; b1 = b_i[1]; b2 = b_i[2];
    pr_d[0][0] = a1 * b2;
    pr_d[0][1] = a2 * b1;
    pr_d[1][0] = a2 * b0;
    pr_d[1][1] = a0 * b2;
    pr_d[2][0] = a0 * b1;
    pr_d[2][1] = a1 * b0;
    dp_d[0]    = a0 * b0;
    dp_d[1]    = a1 * b1;
    dp_d[2]    = a2 * b2;
  end

  // Fallback axis when a and b are near parallel.
  always_comb begin
    a0mag = a1_q[0][BasisW-1] ? -a1_q[0] : a1_q[0];
    if (a0mag > CosLimQ30) begin
      alt_d[0] = CrossW'(signed'(a1_q[1]));
      alt_d[1] = -CrossW'(signed'(a1_q[0]));
      alt_d[2] = '0;
    end else begin
      alt_d[0] = '0;
      alt_d[1] = -CrossW'(signed'(a1_q[2]));
      alt_d[2] = CrossW'(signed'(a1_q[1]));
    end
  end

  assign dmag = dot2_q[63] ? -dot2_q : dot2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pr1_q <= pr_d;
    dp1_q <= dp_d;
    a1_q  <= a_i;
    sd1_q <= side_i;
    for (int i = 0; i < 3; i++) begin
      cr2_q[i] <= CrossW'(pr1_q[i][0] - pr1_q[i][1]);
    end
    dot2_q <= dp1_q[0] + dp1_q[1] + dp1_q[2];
    alt2_q <= alt_d;
    sd2_q  <= sd1_q;
    if (PAR_EN && (dmag > 64'(CosLimQ60))) c3_q <= alt2_q;
    else c3_q <= cr2_q;
    sd3_q <= sd2_q;
  end

  assign valid_o = v3_q;
  assign c_o     = c3_q;
  assign side_o  = sd3_q;

endmodule

// File: rtl/fbt_xform.sv
module fbt_xform import fbt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  fbt_head_t              head_i,
  input  logic [2:0][BasisW-1:0] xb_i,
  input  logic [2:0][BasisW-1:0] yb_i,
  input  logic [2:0][BasisW-1:0] zb_i,
  input  logic [ScaleW-1:0]      scale_i,
  output logic                   valid_o,
  output fbt_out_t               res_o
);

  logic                            v1_q, v2_q, v3_q;
  logic                            act1_q;
  logic signed [2:0][63:0]         fp1_q;
  logic signed [2:0][2:0][63:0]    ip1_q;
  logic [2:0][2:0][BasisW-1:0]     m1_q, m2_q;
  logic signed [2:0][47:0]         tv2_q;
  fbt_out_t                        res_q;

  logic signed [2:0][63:0]         fp_d;
  logic signed [2:0][2:0][63:0]    ip_d;
  logic [2:0][2:0][BasisW-1:0]     m_d;
  logic signed [2:0][47:0]         tv_d;
  logic [2:0][BasisW-1:0]          bs [3];

  assign bs[0] = xb_i;
  assign bs[1] = yb_i;
  assign bs[2] = zb_i;

  // Rows come from the basis in the inverse and from its columns forward.
  always_comb begin
    logic signed [CoordW-1:0] p;
    logic signed [BasisW-1:0] r;
    logic signed [CoordW:0]   sc;
    sc = {1'b0, scale_i};
    for (int i = 0; i < 3; i++) begin
      p = head_i.pos[i];
      fp_d[i] = p * sc;
      for (int j = 0; j < 3; j++) begin
        p = head_i.pos[j];
        r = bs[i][j];
        ip_d[i][j] = p * r;
        m_d[i][j] = (head_i.action == ActInverse) ? bs[i][j] : bs[j][i];
      end
    end
  end

  always_comb begin
    logic signed [64:0] acc;
    logic signed [63:0] fr;
    for (int i = 0; i < 3; i++) begin
      acc = -(65'(signed'(ip1_q[i][0])) + 65'(signed'(ip1_q[i][1]))
              + 65'(signed'(ip1_q[i][2]))) + 65'sd536870912;
      fr  = fp1_q[i] + 64'sd32768;
      if (act1_q == ActInverse) tv_d[i] = 48'(acc >>> 30);
      else tv_d[i] = 48'(fr >>> 16);
    end
  end

  function automatic logic [CoordW-1:0] sat(input logic signed [47:0] v);
    logic [CoordW-1:0] r;
    if (v > 48'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -48'sd2147483648) r = 32'h8000_0000;
    else r = v[CoordW-1:0];
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    act1_q <= head_i.action;
    fp1_q  <= fp_d;
    ip1_q  <= ip_d;
    m1_q   <= m_d;
    m2_q   <= m1_q;
    tv2_q  <= tv_d;
    res_q.m00 <= m2_q[0][0];
    res_q.m01 <= m2_q[0][1];
    res_q.m02 <= m2_q[0][2];
    res_q.m10 <= m2_q[1][0];
    res_q.m11 <= m2_q[1][1];
    res_q.m12 <= m2_q[1][2];
    res_q.m20 <= m2_q[2][0];
    res_q.m21 <= m2_q[2][1];
    res_q.m22 <= m2_q[2][2];
    res_q.t0  <= sat(tv2_q[0]);
    res_q.t1  <= sat(tv2_q[1]);
    res_q.t2  <= sat(tv2_q[2]);
  end

  assign valid_o = v3_q;
  assign res_o   = res_q;

endmodule

// File: rtl/frame_basis_transform_core.sv
// Frame basis transform: each accepted word (start high while busy is low)
// yields exactly one result word, shown on res_o for the single cycle in
// which done_o is high; the receiver cannot stall, so busy stays low and a
// new word may be issued in every clock cycle. From acceptance to done_o a
// word passes through three vector normalisers in series (each built around
// a 31-stage square root and a 31-stage divider), two cross-product stages
// and an output stage.
// The scale register is written through the cfg port, which is always ready;
// it should only be written while no word is in flight.
module frame_basis_transform_core import fbt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  fbt_in_t           in_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [ScaleW-1:0] cfg_data_i,
  output logic              done_o,
  output fbt_out_t          res_o
);

  // The scale register, applied to the forward translation.
  logic [ScaleW-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      scale_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  // Stage one: the axis and the up hint are normalised side by side, with
  // the position and action riding along the axis normaliser.
  logic                   acc_in;
  fbt_head_t              head_in;
  logic [2:0][CoordW-1:0] axis_v, up_v;

  assign acc_in       = start && !busy;
  assign head_in.action = in_i.action;
  assign head_in.pos  = {in_i.pos_z, in_i.pos_y, in_i.pos_x};
  assign axis_v       = {in_i.axis_z, in_i.axis_y, in_i.axis_x};
  assign up_v         = {in_i.up_z, in_i.up_y, in_i.up_x};

  logic                   xv;
  logic [2:0][BasisW-1:0] xb, ub;
  fbt_head_t              head_x;

  fbt_norm #(.IN_W(CoordW), .SIDE_W($bits(fbt_head_t))) u_norm_x (
    .clk_i, .rst_ni,
    .valid_i (acc_in),
    .vec_i   (axis_v),
    .side_i  (head_in),
    .valid_o (xv),
    .vec_o   (xb),
    .side_o  (head_x)
  );

  fbt_norm #(.IN_W(CoordW), .SIDE_W(1)) u_norm_u (
    .clk_i, .rst_ni,
    .valid_i (acc_in),
    .vec_i   (up_v),
    .side_i  (1'b0),
    .valid_o (),
    .vec_o   (ub),
    .side_o  ()
  );

  // Stage two: z direction from x cross up, or from a fallback axis formed
  // from x when the two are within the 0.98 cosine limit of parallel.
  fbt_side1_t             s1_in, s1_c, s1_z;
  logic                   cv1, zv;
  logic [2:0][CrossW-1:0] c1;
  logic [2:0][BasisW-1:0] zb;

  assign s1_in.head = head_x;
  assign s1_in.xb   = xb;

  fbt_cross #(.PAR_EN(1'b1), .SIDE_W($bits(fbt_side1_t))) u_cross_z (
    .clk_i, .rst_ni,
    .valid_i (xv),
    .a_i     (xb),
    .b_i     (ub),
    .side_i  (s1_in),
    .valid_o (cv1),
    .c_o     (c1),
    .side_o  (s1_c)
  );

  fbt_norm #(.IN_W(CrossW), .SIDE_W($bits(fbt_side1_t))) u_norm_z (
    .clk_i, .rst_ni,
    .valid_i (cv1),
    .vec_i   (c1),
    .side_i  (s1_c),
    .valid_o (zv),
    .vec_o   (zb),
    .side_o  (s1_z)
  );

  // Stage three: y direction from z cross x, normalised again so that the
  // rounding of the first two axes does not leak into it.
  fbt_side2_t             s2_in, s2_c, s2_y;
  logic                   cv2, yv;
  logic [2:0][CrossW-1:0] c2;
  logic [2:0][BasisW-1:0] yb;

  assign s2_in.head = s1_z.head;
  assign s2_in.xb   = s1_z.xb;
  assign s2_in.zb   = zb;

  fbt_cross #(.PAR_EN(1'b0), .SIDE_W($bits(fbt_side2_t))) u_cross_y (
    .clk_i, .rst_ni,
    .valid_i (zv),
    .a_i     (zb),
    .b_i     (s1_z.xb),
    .side_i  (s2_in),
    .valid_o (cv2),
    .c_o     (c2),
    .side_o  (s2_c)
  );

  fbt_norm #(.IN_W(CrossW), .SIDE_W($bits(fbt_side2_t))) u_norm_y (
    .clk_i, .rst_ni,
    .valid_i (cv2),
    .vec_i   (c2),
    .side_i  (s2_c),
    .valid_o (yv),
    .vec_o   (yb),
    .side_o  (s2_y)
  );

  // Final stage: lay the basis out as columns or rows and form the
  // translation, either scaled position or minus the rotated position.
  fbt_xform u_xform (
    .clk_i, .rst_ni,
    .valid_i (yv),
    .head_i  (s2_y.head),
    .xb_i    (s2_y.xb),
    .yb_i    (yb),
    .zb_i    (s2_y.zb),
    .scale_i (scale_q),
    .valid_o (done_o),
    .res_o   (res_o)
  );

endmodule

// File: bench/tb_frame_basis_transform_core.sv
`timescale 1ns / 1ps

// Self-checking bench for the frame basis transform core. A behavioural
// predictor builds the orthonormal basis and the translation for every word
// that the core accepts, and a queue of predicted transforms is compared,
// field by field, with each word that the core presents with done_o high.
module tb_frame_basis_transform_core;
  import fbt_pkg::*;

  // The drain wait is the core's pipeline depth plus a margin.
  localparam int PipeDepth  = 219;
  localparam int DrainWait  = PipeDepth + 40;
  localparam int CycleLimit = 400000;
  localparam int RandWords  = 1200;

  localparam logic [63:0] Q30One = 64'd1 << 30;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  fbt_in_t           in_i;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [ScaleW-1:0] cfg_data_i;
  logic              done_o;
  fbt_out_t          res_o;

  frame_basis_transform_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .res_o       (res_o)
  );

  // 4 ns clock period.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Shadow copy of the scale register, kept in step with every write.
  logic [ScaleW-1:0] scale_shadow;
  fbt_out_t          transform_q[$];
  int                error_count;
  int                words_sent;
  int                words_checked;
  int                inverse_seen;
  int                parallel_seen;
  longint            cycle_count;
  bit                idle_enabled;

  // Integer square root, rounding down.
  function automatic logic [63:0] sqrt_floor(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    logic [63:0] rem;
    root = 0;
    rem  = n;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Scales a vector to unit length in Q1.30. Magnitudes are first brought
  // so that the largest lies in [2^29, 2^30), truncating on right shifts.
  function automatic void unit_vec(input longint v[3], output longint u[3]);
    logic [63:0] mag[3];
    logic [63:0] peak;
    logic [63:0] sumsq;
    logic [63:0] len;
    logic [63:0] q;
    peak = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? 64'(-v[i]) : 64'(v[i]);
      if (mag[i] > peak) peak = mag[i];
    end
    if (peak == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return;
    end
    while (peak >= Q30One) begin
      peak = peak >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (peak < (Q30One >> 1)) begin
      peak = peak << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    sumsq = 0;
    for (int i = 0; i < 3; i++) sumsq += mag[i] * mag[i];
    len = sqrt_floor(sumsq);
    for (int i = 0; i < 3; i++) begin
      q    = ((mag[i] << 30) + (len >> 1)) / len;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3],
                                 output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // Rounds half up by 2^sh, then clamps to the signed coordinate range.
  function automatic logic [CoordW-1:0] round_clamp(input logic signed [127:0] acc,
                                                    input int sh);
    logic signed [127:0] r;
    r = (acc + (128'sd1 <<< (sh - 1))) >>> sh;
    if (r > 128'sd2147483647) return 32'h7fff_ffff;
    if (r < -128'sd2147483648) return 32'h8000_0000;
    return r[CoordW-1:0];
  endfunction

  // Predicts the transform that the core should give for one word.
  function automatic fbt_out_t predict_transform(input fbt_in_t w,
                                                 output bit parallel);
    longint pos[3], axis[3], upv[3];
    longint xb[3], ub[3], tmp[3], zb[3], yb[3];
    longint rows[3][3];
    logic signed [127:0] dotp;
    logic signed [127:0] acc;
    logic [127:0] mag_dot;
    longint mag_x0;
    logic [CoordW-1:0] tr[3];
    fbt_out_t o;
    pos  = '{longint'(w.pos_x), longint'(w.pos_y), longint'(w.pos_z)};
    axis = '{longint'(w.axis_x), longint'(w.axis_y), longint'(w.axis_z)};
    upv  = '{longint'(w.up_x), longint'(w.up_y), longint'(w.up_z)};
    unit_vec(axis, xb);
    unit_vec(upv, ub);
    dotp = 0;
    for (int i = 0; i < 3; i++) dotp += 128'(xb[i]) * 128'(ub[i]);
    mag_dot  = dotp < 0 ? -dotp : dotp;
    parallel = mag_dot > 128'(CosLimQ60);
    if (parallel) begin
      // Swap in a substitute z direction, chosen by how close the axis is to x.
      mag_x0 = xb[0] < 0 ? -xb[0] : xb[0];
      if (mag_x0 > longint'(CosLimQ30)) tmp = '{xb[1], -xb[0], 0};
      else tmp = '{0, -xb[2], xb[1]};
    end else begin
      cross3(xb, ub, tmp);
    end
    unit_vec(tmp, zb);
    cross3(zb, xb, tmp);
    unit_vec(tmp, yb);
    if (w.action == ActForward) begin
      for (int i = 0; i < 3; i++) begin
        rows[i] = '{xb[i], yb[i], zb[i]};
        acc     = 128'(pos[i]) * 128'($signed({1'b0, scale_shadow}));
        tr[i]   = round_clamp(acc, 16);
      end
    end else begin
      rows = '{xb, yb, zb};
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += 128'(pos[j]) * 128'(rows[i][j]);
        tr[i] = round_clamp(-acc, 30);
      end
    end
    o.m00 = rows[0][0][31:0]; o.m01 = rows[0][1][31:0]; o.m02 = rows[0][2][31:0];
    o.m10 = rows[1][0][31:0]; o.m11 = rows[1][1][31:0]; o.m12 = rows[1][2][31:0];
    o.m20 = rows[2][0][31:0]; o.m21 = rows[2][1][31:0]; o.m22 = rows[2][2][31:0];
    o.t0 = tr[0]; o.t1 = tr[1]; o.t2 = tr[2];
    return o;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      error_count++;
    end
  endtask

  // Result checker: each word flagged by done_o is matched against the
  // oldest outstanding prediction.
  always @(posedge clk_i) begin
    fbt_out_t want;
    if (rst_ni && done_o) begin
      if (transform_q.size() == 0) begin
        $error("result word with no prediction outstanding");
        error_count++;
      end else begin
        want = transform_q.pop_front();
        words_checked++;
        compare_field("m00", want.m00, res_o.m00);
        compare_field("m01", want.m01, res_o.m01);
        compare_field("m02", want.m02, res_o.m02);
        compare_field("m10", want.m10, res_o.m10);
        compare_field("m11", want.m11, res_o.m11);
        compare_field("m12", want.m12, res_o.m12);
        compare_field("m20", want.m20, res_o.m20);
        compare_field("m21", want.m21, res_o.m21);
        compare_field("m22", want.m22, res_o.m22);
        compare_field("t0", want.t0, res_o.t0);
        compare_field("t1", want.t1, res_o.t1);
        compare_field("t2", want.t2, res_o.t2);
      end
    end
  end

  // Watchdog on run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Random idle burst, taken now and then when enabled.
  task automatic maybe_idle();
    int gap;
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Presents one word and holds it until the core accepts it. start stays
  // high between back-to-back words, so it is only lowered when idling or draining.
  task automatic send_word(input fbt_in_t w);
    bit par;
    maybe_idle();
    in_i  = w;
    start = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    transform_q.insert(transform_q.size(), predict_transform(w, par));
    words_sent++;
    if (w.action == ActInverse) inverse_seen++;
    if (par) parallel_seen++;
    @(negedge clk_i);
  endtask

  // Waits until every prediction has been matched, then lets the pipeline
  // settle before any register write.
  task automatic drain();
    start = 1'b0;
    while (transform_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_scale(input logic [ScaleW-1:0] value);
    cfg_data_i  = value;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    scale_shadow = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic fbt_in_t make_word(input logic act,
      input int px, input int py, input int pz,
      input int ax, input int ay, input int az,
      input int ux, input int uy, input int uz);
    fbt_in_t w;
    w.action = act;
    w.pos_x = px; w.pos_y = py; w.pos_z = pz;
    w.axis_x = ax; w.axis_y = ay; w.axis_z = az;
    w.up_x = ux; w.up_y = uy; w.up_z = uz;
    return w;
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h3_0000)) - 32'h1_8000;
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      3: return $signed($urandom_range(0, 15)) - 8;
      default: return $signed($urandom()) >>> $urandom_range(0, 30);
    endcase
  endfunction

  // Directed words: field extremes, both actions, zero axis and zero up,
  // and near-parallel up vectors on both substitute branches.
  task automatic test_directed();
    logic act;
    for (int k = 0; k < 2; k++) begin
      act = k ? ActInverse : ActForward;
      send_word(make_word(act, 65536, -65536, 3 << 16, 65536, 0, 0, 0, 65536, 0));
      send_word(make_word(act, 5, 6, 7, 0, 0, 0, 0, 65536, 0));
      send_word(make_word(act, 1, 2, 3, 0, 65536, 0, 0, 0, 0));
      send_word(make_word(act, 9, 9, 9, 65536, 100, 0, 65536, 0, 0));
      send_word(make_word(act, 9, 9, 9, 100, 65536, 0, 0, -65536, 10));
      send_word(make_word(act, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                          32'h7fffffff, 32'h7fffffff, 32'h80000000,
                          32'h80000000, 32'h7fffffff, 32'h7fffffff));
      send_word(make_word(act, 32'h80000000, 32'h80000000, 32'h80000000,
                          32'h80000000, 32'h80000000, 32'h80000000,
                          32'h80000000, 32'h80000000, 1));
      send_word(make_word(act, -1, -1, -1, 1, 1, 1, -1, 1, 0));
      send_word(make_word(act, 0, 0, 0, 0, 0, -3, 2, 0, 0));
      send_word(make_word(act, 32'h7fffffff, 0, 0, 0, 0, 0, 0, 0, 0));
    end
    drain();
  endtask

  task automatic test_random(input int count);
    fbt_in_t w;
    int sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 9);
      w = make_word(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord());
      // Some words take an up vector derived from the axis with one component negated.
      if (sel == 0) begin
        w.up_x = w.axis_x + $signed($urandom_range(0, 6)) - 3;
        w.up_y = w.axis_y;
        w.up_z = -w.axis_z;
      end else if (sel == 1) begin
        w.up_x = -w.axis_x; w.up_y = w.axis_y; w.up_z = w.axis_z;
      end
      send_word(w);
    end
    drain();
  endtask

  task automatic test_scale_settings();
    write_scale(ScaleW'(1));
    test_random(RandWords / 8);
    write_scale({ScaleW{1'b1}});
    test_random(RandWords / 8);
    write_scale(ScaleW'($urandom_range(1, 32'h7fff_ffff)));
    test_random(RandWords / 4);
  endtask

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    in_i          = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    scale_shadow  = ScaleReset;
    error_count   = 0;
    words_sent    = 0;
    words_checked = 0;
    inverse_seen  = 0;
    parallel_seen = 0;
    cycle_count   = 0;
    idle_enabled  = 1'b1;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(RandWords / 4);
    test_scale_settings();
    write_scale(ScaleReset);
    // Final stretch runs flat out with no idling.
    idle_enabled = 1'b0;
    test_random(RandWords / 4);

    $display("Covered %0d transforms (%0d inverse, %0d with a substitute up vector).",
             words_sent, inverse_seen, parallel_seen);
    $display("Checked %0d result words across four scale settings.", words_checked);
    if (error_count == 0 && transform_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/fbt_pkg.sv
rtl/fbt_norm.sv
rtl/fbt_cross.sv
rtl/fbt_xform.sv
rtl/frame_basis_transform_core.sv
bench/tb_frame_basis_transform_core.sv
